### src/wgo_pkg.sv
// Shared types and constants for the wheel and gyro odometry block.
package wgo_pkg;

  localparam int AngleW   = 12;
  localparam int GyroW    = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 40;
  localparam int OutDataW = 264;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_MUL_L,
    ST_PREP,
    ST_DIV_R,
    ST_DIV_L,
    ST_RATE_A,
    ST_RATE_B,
    ST_RATE_C,
    ST_RATE_D,
    ST_RATE_E,
    ST_RATE_F,
    ST_SUMS,
    ST_DONE
  } state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MM_PER_PULSE = 1'b0,
    CFG_GYRO_OFFSET  = 1'b1
  } cfg_idx_e;

  // half a revolution of the encoder
  localparam logic [AngleW-1:0] HalfRev = 12'd2048;

  // x / 10 == (x * Recip10) >> 35 for any 32-bit x
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;
  localparam logic [31:0] RoundFive = 32'd5;

  // rad/s scale reduced to 69 + RateRem / (2^14 * RateDivisor)
  localparam logic [31:0] RateRem     = 32'd187584797;
  localparam logic [43:0] RateHalf    = 44'd115040256;
  localparam logic [31:0] RateRecip   = 32'd1252737025;
  localparam logic [31:0] RateDivisor = 32'd14043;

  localparam logic [18:0] HeadRound = 19'd16383;
  localparam logic [15:0] HeadDiv   = 16'd32767;

  localparam logic [22:0] RateMaxMag = 23'd4194303;
  localparam logic [22:0] RateMinMag = 23'd4194304;
  localparam logic signed [22:0] RateMax = 23'sd4194303;
  localparam logic signed [22:0] RateMin = -23'sd4194304;

  localparam logic signed [55:0] SumHi = 56'sd19660800000000000;
  localparam logic signed [55:0] SumLo = -56'sd655360000000000;

endpackage

### src/wheel_gyro_odometry.sv
// Wheel encoder and gyro odometry: one shared multiplier under a step sequencer.
//
//  channel   | dir | payload (lowest bit up)
//  ----------+-----+------------------------------------------------------------
//  s_axis    | in  | right_angle 12, left_angle 12, gyro_raw 16
//  m_axis    | out | body_speed 28, speed_integral 56, distance 48,
//            |     | angular_rate 23, rate_integral 56, heading 48, pad 5
//  cfg       | in  | index 0 mm_per_pulse, index 1 gyro_offset
//
// One word is accepted and then passes 13 sequencer steps, seven of
// which go through the single 32x32 multiplier (speeds, two divides by ten,
// rate scaling with reciprocal and remainder check).
// The result sits in an output register; the next word is taken while it waits.
// The last step holds while the output register is full and its word is not taken.
// Reset clears configuration, angle history, filters and all sums.
module wheel_gyro_odometry import wgo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // right_angle[11:0], left_angle[23:12], gyro_raw[39:24]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // body_speed[27:0], speed_integral[83:28], distance[131:84],
  // angular_rate[154:132], rate_integral[210:155], heading[258:211]
  output logic [OutDataW-1:0] m_axis_tdata
);

  function automatic logic signed [12:0] wrap_delta(input logic [AngleW-1:0] diff);
    logic signed [12:0] d;
    d = (diff > HalfRev) ? {1'b1, diff} : {1'b0, diff};
    return d;
  endfunction

  state_e state_q, state_d;

  logic [15:0]        mpp_q;
  logic [15:0]        goff_q;
  logic [11:0]        last_r_q, last_r_d, last_l_q, last_l_d;
  logic signed [27:0] fr_q, fr_d, fl_q, fl_d;
  logic signed [55:0] speed_sum_q, speed_sum_d, rate_sum_q, rate_sum_d;
  logic [47:0]        travel_q, travel_d, heading_q, heading_d;
  logic               out_valid_q, out_valid_d;

  logic signed [12:0] dr_q, dr_d, dl_q, dl_d;
  logic               g_neg_q, g_neg_d;
  logic [15:0]        g_mag_q, g_mag_d;
  logic [63:0]        prod_q;
  logic signed [28:0] new_r_q, new_r_d, new_l_q, new_l_d;
  logic [31:0]        nr_mag_q, nr_mag_d, nl_mag_q, nl_mag_d;
  logic               nr_neg_q, nr_neg_d, nl_neg_q, nl_neg_d;
  logic signed [27:0] body_q, body_d;
  logic [29:0]        y_q, y_d;
  logic [16:0]        q1_q, q1_d, rq_q, rq_d;
  logic signed [22:0] rate_q, rate_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        accept, load_out;

  logic [11:0]        in_ra, in_la;
  logic signed [16:0] g_in;
  logic [15:0]        g_in_mag;
  logic [11:0]        dr_mag, dl_mag;
  logic [27:0]        wheel_mag;
  logic [27:0]        div_mag;
  logic signed [31:0] n_r, n_l;
  logic [29:0]        trav_sum, trav_adj;
  logic [28:0]        body_sum, body_adj;
  logic [18:0]        hx, hstep;
  logic [3:0]         hq0;
  logic [15:0]        hr;
  logic [43:0]        y_full;
  logic [30:0]        rem;
  logic [22:0]        rate_mag;
  logic signed [55:0] speed_raw, rate_raw;

  assign mul_p = mul_a * mul_b;

  assign in_ra    = s_axis_tdata[11:0];
  assign in_la    = s_axis_tdata[23:12];
  assign g_in     = {s_axis_tdata[39], s_axis_tdata[39:24]} - {goff_q[15], goff_q};
  assign g_in_mag = g_in[16] ? 16'(-g_in) : g_in[15:0];

  assign dr_mag    = dr_q[12] ? 12'(-dr_q) : dr_q[11:0];
  assign dl_mag    = dl_q[12] ? 12'(-dl_q) : dl_q[11:0];
  assign wheel_mag = prod_q[27:0];
  assign div_mag   = prod_q[62:35];

  assign n_r = {{3{new_r_q[28]}}, new_r_q} + {{4{fr_q[27]}}, fr_q}
             + {fr_q[27], fr_q, 3'b000};
  assign n_l = {{3{new_l_q[28]}}, new_l_q} + {{4{fl_q[27]}}, fl_q}
             + {fl_q[27], fl_q, 3'b000};

  assign trav_sum = {new_r_q[28], new_r_q} + {new_l_q[28], new_l_q};
  assign trav_adj = trav_sum + {29'd0, trav_sum[29]};
  assign body_sum = {fr_q[27], fr_q} + {fl_q[27], fl_q};
  assign body_adj = body_sum + {28'd0, body_sum[28]};

  // 2^17 * a / 32767 == 4a + (4a + round) / 32767, quotient below nine
  assign hx    = {1'b0, g_mag_q, 2'b00} + HeadRound;
  assign hq0   = hx[18:15];
  assign hr    = {1'b0, hx[14:0]} + {12'd0, hq0};
  assign hstep = {1'b0, g_mag_q, 2'b00} + {15'd0, hq0} + {18'd0, (hr >= HeadDiv)};

  assign y_full   = prod_q[43:0] + RateHalf;
  assign rem      = {1'b0, y_q} - prod_q[30:0];
  assign rate_mag = {7'd0, g_mag_q} + {5'd0, g_mag_q, 2'b00} + {1'b0, g_mag_q, 6'd0}
                  + {6'd0, rq_q};

  assign speed_raw = speed_sum_q + {{28{body_q[27]}}, body_q};
  assign rate_raw  = rate_sum_q + {{33{rate_q[22]}}, rate_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_MUL_R;
      ST_MUL_R:  state_d = ST_MUL_L;
      ST_MUL_L:  state_d = ST_PREP;
      ST_PREP:   state_d = ST_DIV_R;
      ST_DIV_R:  state_d = ST_DIV_L;
      ST_DIV_L:  state_d = ST_RATE_A;
      ST_RATE_A: state_d = ST_RATE_B;
      ST_RATE_B: state_d = ST_RATE_C;
      ST_RATE_C: state_d = ST_RATE_D;
      ST_RATE_D: state_d = ST_RATE_E;
      ST_RATE_E: state_d = ST_RATE_F;
      ST_RATE_F: state_d = ST_SUMS;
      ST_SUMS:   state_d = ST_DONE;
      ST_DONE:   if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    load_out      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
    out_valid_d   = load_out || (out_valid_q && !m_axis_tready);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = out_data_q;
  end

  // datapath steps
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    last_r_d    = last_r_q;
    last_l_d    = last_l_q;
    fr_d        = fr_q;
    fl_d        = fl_q;
    speed_sum_d = speed_sum_q;
    rate_sum_d  = rate_sum_q;
    travel_d    = travel_q;
    heading_d   = heading_q;
    dr_d        = dr_q;
    dl_d        = dl_q;
    g_neg_d     = g_neg_q;
    g_mag_d     = g_mag_q;
    new_r_d     = new_r_q;
    new_l_d     = new_l_q;
    nr_mag_d    = nr_mag_q;
    nl_mag_d    = nl_mag_q;
    nr_neg_d    = nr_neg_q;
    nl_neg_d    = nl_neg_q;
    body_d      = body_q;
    y_d         = y_q;
    q1_d        = q1_q;
    rq_d        = rq_q;
    rate_d      = rate_q;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_r_d = in_ra;
          last_l_d = in_la;
          dr_d     = wrap_delta(in_ra - last_r_q);
          dl_d     = wrap_delta(last_l_q - in_la);
          g_neg_d  = g_in[16];
          g_mag_d  = g_in_mag;
        end
      end
      ST_MUL_R: begin
        mul_a = {20'd0, dr_mag};
        mul_b = {16'd0, mpp_q};
      end
      ST_MUL_L: begin
        new_r_d = dr_q[12] ? -{1'b0, wheel_mag} : {1'b0, wheel_mag};
        mul_a   = {20'd0, dl_mag};
        mul_b   = {16'd0, mpp_q};
      end
      ST_PREP: begin
        new_l_d  = dl_q[12] ? -{1'b0, wheel_mag} : {1'b0, wheel_mag};
        nr_neg_d = n_r[31];
        nr_mag_d = (n_r[31] ? -n_r : n_r) + RoundFive;
      end
      ST_DIV_R: begin
        mul_a    = nr_mag_q;
        mul_b    = Recip10;
        nl_neg_d = n_l[31];
        nl_mag_d = (n_l[31] ? -n_l : n_l) + RoundFive;
        travel_d = travel_q + {{19{trav_adj[29]}}, trav_adj[29:1]};
      end
      ST_DIV_L: begin
        fr_d  = nr_neg_q ? -div_mag : div_mag;
        mul_a = nl_mag_q;
        mul_b = Recip10;
      end
      ST_RATE_A: begin
        fl_d      = nl_neg_q ? -div_mag : div_mag;
        mul_a     = {16'd0, g_mag_q};
        mul_b     = RateRem;
        heading_d = g_neg_q ? heading_q - {29'd0, hstep} : heading_q + {29'd0, hstep};
      end
      ST_RATE_B: begin
        y_d    = y_full[43:14];
        body_d = body_adj[28:1];
      end
      ST_RATE_C: begin
        mul_a = {2'd0, y_q};
        mul_b = RateRecip;
        if (speed_raw > SumHi) begin
          speed_sum_d = SumHi;
        end else if (speed_raw < SumLo) begin
          speed_sum_d = SumLo;
        end else begin
          speed_sum_d = speed_raw;
        end
      end
      ST_RATE_D: begin
        q1_d  = prod_q[60:44];
        mul_a = {15'd0, prod_q[60:44]};
        mul_b = RateDivisor;
      end
      ST_RATE_E: begin
        rq_d = q1_q + {16'd0, (rem >= RateDivisor[30:0])};
      end
      ST_RATE_F: begin
        if (g_neg_q) begin
          rate_d = (rate_mag > RateMinMag) ? RateMin : -rate_mag;
        end else begin
          rate_d = (rate_mag > RateMaxMag) ? RateMax : rate_mag;
        end
      end
      ST_SUMS: begin
        if (rate_raw > SumHi) begin
          rate_sum_d = SumHi;
        end else if (rate_raw < SumLo) begin
          rate_sum_d = SumLo;
        end else begin
          rate_sum_d = rate_raw;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_data_d = {5'd0, heading_q, rate_sum_q, rate_q, travel_q, speed_sum_q, body_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mpp_q       <= '0;
      goff_q      <= '0;
      last_r_q    <= '0;
      last_l_q    <= '0;
      fr_q        <= '0;
      fl_q        <= '0;
      speed_sum_q <= '0;
      rate_sum_q  <= '0;
      travel_q    <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_r_q    <= last_r_d;
      last_l_q    <= last_l_d;
      fr_q        <= fr_d;
      fl_q        <= fl_d;
      speed_sum_q <= speed_sum_d;
      rate_sum_q  <= rate_sum_d;
      travel_q    <= travel_d;
      heading_q   <= heading_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_MM_PER_PULSE: mpp_q  <= cfg_wdata_i;
          CFG_GYRO_OFFSET:  goff_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= mul_p;
    dr_q       <= dr_d;
    dl_q       <= dl_d;
    g_neg_q    <= g_neg_d;
    g_mag_q    <= g_mag_d;
    new_r_q    <= new_r_d;
    new_l_q    <= new_l_d;
    nr_mag_q   <= nr_mag_d;
    nl_mag_q   <= nl_mag_d;
    nr_neg_q   <= nr_neg_d;
    nl_neg_q   <= nl_neg_d;
    body_q     <= body_d;
    y_q        <= y_d;
    q1_q       <= q1_d;
    rq_q       <= rq_d;
    rate_q     <= rate_d;
    out_data_q <= out_data_d;
  end

endmodule

### src/wgo_checker.sv
// Port-level checks for the odometry block, bound to its top level.
module wgo_checker import wgo_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // busy right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again during processing");

  // sequencer keeps the input closed up to the last rate step of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##10 !s_axis_tready)
    else $error("input reopened before the step chain ended");

  // a new result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind wheel_gyro_odometry wgo_checker u_wgo_checker (.*);

### bench/wheel_gyro_odometry_tb.sv
// Self-checking bench for wheel_gyro_odometry: directed and random ticks, scoreboard compare.
`timescale 1ns / 1ps

module wheel_gyro_odometry_tb;
  import wgo_pkg::*;

  localparam int SettleCycles = 20;
  localparam int HangLimit    = 1000;
  localparam int PhaseTicks   = 300;
  localparam int NumPhases    = 6;

  typedef struct packed {
    logic [47:0] heading;
    logic [55:0] rate_integral;
    logic [22:0] angular_rate;
    logic [47:0] distance;
    logic [55:0] speed_integral;
    logic [27:0] body_speed;
  } odo_word_t;

  class odo_scoreboard;
    localparam longint Rev       = 4096;
    localparam longint FiltTop   = 64'sd134217727;
    localparam longint RateTop   = 64'sd4194303;
    localparam longint PiQ32     = 64'sd13493037705;
    localparam longint RateDen   = 64'sd180 * 32767 * 65536;
    localparam longint SumTop    = 64'sd300000000000 * 65536;
    localparam longint SumBottom = -64'sd10000000000 * 65536;

    longint      mm_gain, gyro_zero;
    logic [11:0] prev_right, prev_left;
    longint      filt_right, filt_left, speed_acc, rate_acc;
    logic [47:0] travel_acc, heading_acc;
    odo_word_t   expected_q[$];
    int unsigned errors, checked;

    function new();
      mm_gain = 0;
      gyro_zero = 0;
      prev_right = '0;
      prev_left = '0;
      filt_right = 0;
      filt_left = 0;
      speed_acc = 0;
      rate_acc = 0;
      travel_acc = '0;
      heading_acc = '0;
      errors = 0;
      checked = 0;
    endfunction

    function longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // shorter way round, half a turn counts as forward
    function longint wrap_delta(logic [11:0] from_a, logic [11:0] to_a);
      logic [11:0] diff;
      longint      d;
      diff = to_a - from_a;
      d = longint'(diff);
      if (d > Rev / 2) d -= Rev;
      return d;
    endfunction

    function void set_config(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_MM_PER_PULSE: mm_gain = longint'(v);
        CFG_GYRO_OFFSET:  gyro_zero = longint'(signed'(v));
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void note_tick(logic [InDataW-1:0] w);
      logic [11:0] ra, la;
      longint      dr, dl, new_r, new_l, body, g, rate;
      longint      trav_step, head_step;
      odo_word_t   e;
      ra = w[11:0];
      la = w[23:12];
      dr = wrap_delta(prev_right, ra);
      dl = wrap_delta(la, prev_left);
      new_r = dr * mm_gain;
      new_l = dl * mm_gain;
      prev_right = ra;
      prev_left = la;

      filt_right = clamp(round_div(new_r + 9 * filt_right, 10), -FiltTop - 1, FiltTop);
      filt_left = clamp(round_div(new_l + 9 * filt_left, 10), -FiltTop - 1, FiltTop);
      body = (filt_right + filt_left) / 2;
      speed_acc = clamp(speed_acc + body, SumBottom, SumTop);
      trav_step = (new_r + new_l) / 2;
      travel_acc = travel_acc + trav_step[47:0];

      g = longint'(signed'(w[39:24])) - gyro_zero;
      rate = clamp(round_div(g * 2000 * PiQ32, RateDen), -RateTop - 1, RateTop);
      rate_acc = clamp(rate_acc + rate, SumBottom, SumTop);
      head_step = round_div(g * 2 * 65536, 32767);
      heading_acc = heading_acc + head_step[47:0];

      e.body_speed = body[27:0];
      e.speed_integral = speed_acc[55:0];
      e.distance = travel_acc;
      e.angular_rate = rate[22:0];
      e.rate_integral = rate_acc[55:0];
      e.heading = heading_acc;
      expected_q.push_back(e);
    endfunction

    function void cmp(string fname, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] w);
      odo_word_t got, e;
      got = w[258:0];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual %h", $time, w);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      cmp("body_speed", 64'(e.body_speed), 64'(got.body_speed));
      cmp("speed_integral", 64'(e.speed_integral), 64'(got.speed_integral));
      cmp("distance", 64'(e.distance), 64'(got.distance));
      cmp("angular_rate", 64'(e.angular_rate), 64'(got.angular_rate));
      cmp("rate_integral", 64'(e.rate_integral), 64'(got.rate_integral));
      cmp("heading", 64'(e.heading), 64'(got.heading));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // right_angle[11:0], left_angle[23:12], gyro_raw[39:24]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // body_speed[27:0], speed_integral[83:28], distance[131:84],
  // angular_rate[154:132], rate_integral[210:155], heading[258:211]
  logic [OutDataW-1:0] m_axis_tdata;

  odo_scoreboard sb = new();
  bit            idle_en = 1'b1;
  int            ready_hold = 0;
  int            quiet_cycles = 0;
  int unsigned   ticks_sent = 0;
  int unsigned   settings_used = 0;
  logic [11:0]   cur_right = '0, cur_left = '0;
  logic [15:0]   cur_offset = '0;

  wheel_gyro_odometry dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_tick(s_axis_tdata);
        ticks_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HangLimit) begin
      $display("%0t: timeout, %0d words outstanding", $time, sb.outstanding());
      $display("wheel_gyro_odometry test failed");
      $finish;
    end
  end

  task automatic send_tick(input logic [11:0] ra, input logic [11:0] la,
                           input logic [15:0] gr);
    int n;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata <= {gr, la, ra};
    s_axis_tvalid <= 1'b1;
    cur_right = ra;
    cur_left = la;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_pipe();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(idx, v);
    if (idx == CFG_GYRO_OFFSET) cur_offset = v;
  endtask

  task automatic set_pair(input logic [15:0] mm, input logic [15:0] ofs);
    drain_pipe();
    cfg_write(CFG_MM_PER_PULSE, mm);
    cfg_write(CFG_GYRO_OFFSET, ofs);
    settings_used++;
  endtask

  task automatic run_random(input int count);
    logic [11:0] ra, la;
    logic [15:0] gr;
    int          span;
    repeat (count) begin
      case ($urandom_range(0, 9))
        7: begin
          ra = 12'($urandom);
          la = 12'($urandom);
        end
        8: begin
          // around half a turn, the wrap boundary
          ra = 12'(cur_right + 2047 + $urandom_range(0, 2));
          la = 12'(cur_left + 2047 + $urandom_range(0, 2));
        end
        9: begin
          ra = 12'(cur_right + $urandom_range(0, 2) - 1);
          la = 12'(cur_left + $urandom_range(0, 2) - 1);
        end
        default: begin
          span = 1 << $urandom_range(0, 11);
          ra = 12'(cur_right + $urandom_range(0, 2 * span) - span);
          la = 12'(cur_left + $urandom_range(0, 2 * span) - span);
        end
      endcase
      if ($urandom_range(0, 3) == 0) gr = 16'(cur_offset + $urandom_range(0, 64) - 32);
      else gr = 16'($urandom);
      send_tick(ra, la, gr);
      if ($urandom_range(0, 99) == 0) drain_pipe();
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    settings_used = 1;

    // reset configuration: no wheel scale, no gyro offset
    send_tick(12'd0, 12'd0, 16'h0000);
    send_tick(12'd4095, 12'd4095, 16'hFFFF);
    send_tick(12'd2048, 12'd0, 16'h7FFF);

    set_pair(16'hFFFF, 16'h8000);
    send_tick(12'd0, 12'd2048, 16'h7FFF);
    send_tick(12'd2049, 12'd4095, 16'h8000);
    send_tick(12'd2048, 12'd0, 16'h0000);
    send_tick(12'd4095, 12'd4095, 16'h7FFF);
    send_tick(12'd0, 12'd0, 16'hFFFF);
    repeat (3) send_tick(12'd0, 12'd0, 16'h8000);

    set_pair(16'hFFFF, 16'h7FFF);
    send_tick(12'd4095, 12'd1, 16'h8000);
    send_tick(12'd1, 12'd4094, 16'h7FFF);
    send_tick(12'hAAA, 12'h555, 16'h5555);
    send_tick(12'h555, 12'hAAA, 16'hAAAA);

    set_pair(16'h0001, 16'h0000);
    send_tick(12'd0, 12'd0, 16'h0001);
    send_tick(12'd2048, 12'd2048, 16'hFFFF);
    send_tick(12'd4095, 12'd0, 16'h3FFF);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1: set_pair(16'hFFFF, 16'h8000);
        2: set_pair(16'h0000, 16'h7FFF);
        3: set_pair(16'h0001, 16'($urandom_range(0, 200)) - 16'd100);
        default: set_pair(16'($urandom), 16'($urandom));
      endcase
      idle_en = (p != NumPhases - 1);
      run_random(PhaseTicks);
    end

    drain_pipe();
    $display("%0d ticks over %0d gain/offset settings, %0d words checked, %0d mismatches",
             ticks_sent, settings_used, sb.checked, sb.errors);
    $display("covered wrap ties, rate saturation, offset extremes and filter decay");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("wheel_gyro_odometry test passed");
    end else begin
      $display("wheel_gyro_odometry test failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/wgo_pkg.sv
src/wheel_gyro_odometry.sv
src/wgo_checker.sv
bench/wheel_gyro_odometry_tb.sv
